### hdl/sumcfr_pkg.sv
// Shared types and constants for the sum-checksum frame receiver.
`default_nettype none
package sumcfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_BYTE_LENGTH = 2'd2;

    localparam logic [BYTE_W-1:0]  MIN_LEN_ONE_BYTE = 8'd7;
    localparam logic [INDEX_W-1:0] MIN_LEN_TWO_BYTE = 16'd8;
    localparam logic [INDEX_W-1:0] INDEX_MAX        = 16'hFFFF;
    localparam logic [INDEX_W-1:0] IDX_LEN_BYTE     = 16'd3;
    localparam logic [INDEX_W-1:0] IDX_LEN_LOW      = 16'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] head_byte;
        logic [BYTE_W-1:0] tail_byte;
        logic              two_byte_length;
    } cfg_t;

    typedef struct packed {
        logic [INDEX_W-1:0] byte_count;
        logic [BYTE_W-1:0]  length_high;
        logic [INDEX_W-1:0] total_len;
        logic [BYTE_W-1:0]  running_sum;
        logic [BYTE_W-1:0]  previous_byte;
    } frame_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               frame_end;
        logic               frame_good;
        logic               frame_abort;
    } result_t;

endpackage
`default_nettype wire

### hdl/sumcfr_step.sv
// Per-byte frame state update and result forming.
`default_nettype none
module sumcfr_step (
    input  wire sumcfr_pkg::cfg_t         cfg,
    input  wire sumcfr_pkg::frame_state_t st,
    input  wire [sumcfr_pkg::BYTE_W-1:0]  rx_byte,
    output sumcfr_pkg::frame_state_t      st_next,
    output logic                          emit,
    output sumcfr_pkg::result_t           res
);
    import sumcfr_pkg::*;

    logic [INDEX_W-1:0] idx;
    logic [INDEX_W-1:0] len16;
    logic [INDEX_W-1:0] flen_eff;
    logic [INDEX_W:0]   idx_plus1;
    logic [BYTE_W-1:0]  sum_chk;
    logic               abort_len;
    logic               end_now;
    logic               good_now;
    logic               abort_now;

    assign idx       = st.byte_count;
    assign len16     = {st.length_high, rx_byte};
    assign idx_plus1 = {1'b0, idx} + {{INDEX_W{1'b0}}, 1'b1};
    assign sum_chk   = st.running_sum - st.previous_byte;

    always_comb begin
        abort_len = 1'b0;
        flen_eff  = st.total_len;
        if (idx == IDX_LEN_BYTE) begin
            if (!cfg.two_byte_length) begin
                if (rx_byte < MIN_LEN_ONE_BYTE) begin
                    abort_len = 1'b1;
                end else begin
                    flen_eff = {{(INDEX_W-BYTE_W){1'b0}}, rx_byte};
                end
            end
        end else if (idx == IDX_LEN_LOW && cfg.two_byte_length) begin
            if (len16 < MIN_LEN_TWO_BYTE) begin
                abort_len = 1'b1;
            end else begin
                flen_eff = len16;
            end
        end
    end

    assign end_now   = !abort_len && (flen_eff != '0) && (idx_plus1 == {1'b0, flen_eff});
    assign good_now  = end_now && (rx_byte == cfg.tail_byte) && (sum_chk == st.previous_byte);
    assign abort_now = abort_len || (!end_now && idx == INDEX_MAX);

    always_comb begin
        st_next = st;
        emit    = 1'b0;
        res.data_byte   = rx_byte;
        res.byte_index  = idx;
        res.frame_end   = 1'b0;
        res.frame_good  = 1'b0;
        res.frame_abort = 1'b0;
        if (idx == '0) begin
            // hunting: only the head byte opens a frame
            if (rx_byte == cfg.head_byte) begin
                emit                  = 1'b1;
                st_next               = '0;
                st_next.byte_count    = {{(INDEX_W-1){1'b0}}, 1'b1};
                st_next.previous_byte = rx_byte;
            end
        end else begin
            emit            = 1'b1;
            res.frame_end   = end_now;
            res.frame_good  = good_now;
            res.frame_abort = abort_now;
            if (abort_now || end_now) begin
                st_next = '0;
            end else begin
                st_next.byte_count    = idx_plus1[INDEX_W-1:0];
                st_next.running_sum   = st.running_sum + rx_byte;
                st_next.previous_byte = rx_byte;
                st_next.total_len     = flen_eff;
                if (idx == IDX_LEN_BYTE) begin
                    st_next.length_high = rx_byte;
                end
            end
        end
    end

endmodule
`default_nettype wire

### hdl/sum_checksum_frame_receiver.sv
// Top level of the head/length/sum8/tail frame receiver.
// Takes one received byte per item and hunts for the head byte, then echoes
// every byte of the frame with its index, flagging frame end (with a good/bad
// verdict from the tail byte and 8-bit sum) or an abort on a short length or
// index overflow. Throughput is one item per clock unless the output stalls; each result
// appears in the cycle after its item, from a single result register whose ready path
// is s_ready = !m_valid || m_ready. Bytes skipped while hunting give no result. The user
// must write configuration via cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not enforce it.
`default_nettype none
module sum_checksum_frame_receiver (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire [sumcfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [sumcfr_pkg::BYTE_W-1:0]       cfg_wdata,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire [sumcfr_pkg::BYTE_W-1:0]       s_rx_byte,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [sumcfr_pkg::BYTE_W-1:0]      m_data_byte,
    output logic [sumcfr_pkg::INDEX_W-1:0]     m_byte_index,
    output logic                               m_frame_end,
    output logic                               m_frame_good,
    output logic                               m_frame_abort
);
    import sumcfr_pkg::*;

    cfg_t         cfg_reg;
    frame_state_t st_reg;
    frame_state_t st_next;
    result_t      res_reg;
    result_t      res_next;
    logic         m_valid_reg;
    logic         emit;
    logic         s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    sumcfr_step u_step (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .rx_byte (s_rx_byte),
        .st_next (st_next),
        .emit    (emit),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_HEAD_BYTE) begin
                cfg_reg.head_byte <= cfg_wdata;
            end else if (cfg_index == REG_TAIL_BYTE) begin
                cfg_reg.tail_byte <= cfg_wdata;
            end else if (cfg_index == REG_TWO_BYTE_LENGTH) begin
                cfg_reg.two_byte_length <= cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                st_reg <= st_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_fire && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data_byte   = res_reg.data_byte;
    assign m_byte_index  = res_reg.byte_index;
    assign m_frame_end   = res_reg.frame_end;
    assign m_frame_good  = res_reg.frame_good;
    assign m_frame_abort = res_reg.frame_abort;

`ifndef SYNTH
    a_stall_only_on_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

    a_end_abort_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_end && m_frame_abort) && (!m_frame_good || m_frame_end))
        else $error("inconsistent frame flags");

    a_hunt_after_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && emit && (res_next.frame_end || res_next.frame_abort))
        |=> (st_reg.byte_count == '0) && (st_reg.total_len == '0))
        else $error("frame state not cleared after frame close");

    a_head_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && emit && st_reg.byte_count == '0) |=> (m_valid && m_byte_index == '0))
        else $error("head byte result carries non-zero index");
`endif

endmodule
`default_nettype wire

### bench/sum_checksum_frame_receiver_test.sv
// Self-checking testbench for the sum-checksum frame receiver.
module sum_checksum_frame_receiver_test;
    import sumcfr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BYTE_W-1:0]    m_data_byte;
    logic [INDEX_W-1:0]   m_byte_index;
    logic                 m_frame_end;
    logic                 m_frame_good;
    logic                 m_frame_abort;

    cfg_t              cfg_model = '0;
    frame_state_t      frame_model = '0;
    result_t           expected_echo[$];
    logic [BYTE_W-1:0] frame_buf[$];
    int                taken_bytes = 0;
    int                error_count = 0;
    int                stall_cycles = 0;
    int                send_idle = 0;
    int                recv_idle = 0;

    sum_checksum_frame_receiver u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_index  (m_byte_index),
        .m_frame_end   (m_frame_end),
        .m_frame_good  (m_frame_good),
        .m_frame_abort (m_frame_abort)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic predict_rx(input logic [BYTE_W-1:0] b);
        logic [31:0]        idx;
        logic [INDEX_W-1:0] len2;
        logic [BYTE_W-1:0]  sum;
        logic               ends;
        logic               good;
        logic               drop;
        result_t            r;
        idx = {16'd0, frame_model.byte_count};
        ends = 1'b0;
        good = 1'b0;
        drop = 1'b0;
        if (idx == 0) begin
            if (b == cfg_model.head_byte) begin
                frame_model = '0;
                frame_model.byte_count = 16'd1;
                frame_model.previous_byte = b;
                r = '0;
                r.data_byte = b;
                expected_echo = {expected_echo, r};
                taken_bytes++;
            end
        end else begin
            if (idx == IDX_LEN_BYTE) begin
                frame_model.length_high = b;
                if (!cfg_model.two_byte_length) begin
                    if (b < MIN_LEN_ONE_BYTE)
                        drop = 1'b1;
                    else
                        frame_model.total_len = {8'd0, b};
                end
            end else if (idx == IDX_LEN_LOW && cfg_model.two_byte_length) begin
                len2 = {frame_model.length_high, b};
                if (len2 < MIN_LEN_TWO_BYTE)
                    drop = 1'b1;
                else
                    frame_model.total_len = len2;
            end
            if (!drop && frame_model.total_len != 0
                    && idx + 1 == {16'd0, frame_model.total_len}) begin
                sum = frame_model.running_sum - frame_model.previous_byte;
                ends = 1'b1;
                good = (b == cfg_model.tail_byte) && (sum == frame_model.previous_byte);
            end
            if (!drop && !ends && idx >= {16'd0, INDEX_MAX})
                drop = 1'b1;
            r.data_byte = b;
            r.byte_index = idx[INDEX_W-1:0];
            r.frame_end = ends;
            r.frame_good = good;
            r.frame_abort = drop;
            expected_echo = {expected_echo, r};
            taken_bytes++;
            if (drop || ends) begin
                frame_model = '0;
            end else begin
                frame_model.running_sum = frame_model.running_sum + b;
                frame_model.previous_byte = b;
                frame_model.byte_count = idx[INDEX_W-1:0] + 16'd1;
            end
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_rx(b);
    endtask

    // hold the sender off until every echo is back, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_echo.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_HEAD_BYTE:       cfg_model.head_byte = val;
            REG_TAIL_BYTE:       cfg_model.tail_byte = val;
            REG_TWO_BYTE_LENGTH: cfg_model.two_byte_length = val[0];
            default: ;
        endcase
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int pick_len();
        int min_len;
        min_len = cfg_model.two_byte_length ? int'(MIN_LEN_TWO_BYTE) : int'(MIN_LEN_ONE_BYTE);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(min_len, cfg_model.two_byte_length ? 600 : 255);
        return $urandom_range(min_len, min_len + 25);
    endfunction

    task automatic build_frame(input int len, input bit bad_sum, input bit bad_tail);
        logic [BYTE_W-1:0]  b;
        logic [BYTE_W-1:0]  sum;
        logic [INDEX_W-1:0] l;
        l = len[INDEX_W-1:0];
        sum = '0;
        frame_buf.delete();
        frame_buf = {frame_buf, cfg_model.head_byte};
        for (int i = 1; i <= len - 3; i++) begin
            b = 8'($urandom);
            if (i == 3)
                b = cfg_model.two_byte_length ? l[15:8] : l[7:0];
            else if (i == 4 && cfg_model.two_byte_length)
                b = l[7:0];
            sum = sum + b;
            frame_buf = {frame_buf, b};
        end
        frame_buf = {frame_buf, bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum};
        frame_buf = {frame_buf, bad_tail ? cfg_model.tail_byte ^ 8'($urandom_range(1, 255))
                                         : cfg_model.tail_byte};
    endtask

    task automatic send_buf(input int count);
        for (int i = 0; i < count && i < frame_buf.size(); i++)
            send_byte(frame_buf[i]);
    endtask

    task automatic send_short(input logic [INDEX_W-1:0] len_field);
        send_byte(cfg_model.head_byte);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        if (cfg_model.two_byte_length) begin
            send_byte(len_field[15:8]);
            send_byte(len_field[7:0]);
        end else begin
            send_byte(len_field[7:0]);
        end
    endtask

    // noise bytes never equal the head byte
    task automatic send_random(input int count);
        logic [BYTE_W-1:0] b;
        repeat (count) begin
            b = 8'($urandom);
            if (b == cfg_model.head_byte)
                b = ~b;
            send_byte(b);
        end
    endtask

    // finish an open frame, zero length bytes make it drop early
    task automatic close_frame();
        while (frame_model.byte_count != '0) begin
            if (frame_model.byte_count == IDX_LEN_BYTE
                    || (frame_model.byte_count == IDX_LEN_LOW && cfg_model.two_byte_length))
                send_byte(8'h00);
            else
                send_byte(8'($urandom));
        end
    endtask

    task automatic test_one_byte_frames();
        write_cfg(REG_HEAD_BYTE, 8'hFF);
        write_cfg(REG_TAIL_BYTE, 8'h00);
        write_cfg(REG_TWO_BYTE_LENGTH, 8'd0);
        send_byte(8'h00);
        send_byte(8'h12);
        build_frame(7, 1'b0, 1'b0);
        send_buf(7);
        send_short(16'd6);
        send_short(16'd0);
        build_frame(7, 1'b1, 1'b0);
        send_buf(7);
    endtask

    task automatic test_two_byte_frames();
        drain();
        write_cfg(REG_HEAD_BYTE, 8'h00);
        write_cfg(REG_TAIL_BYTE, 8'hFF);
        write_cfg(REG_TWO_BYTE_LENGTH, 8'd1);
        build_frame(8, 1'b0, 1'b0);
        send_buf(8);
        build_frame(8, 1'b0, 1'b1);
        send_buf(8);
        send_short(16'd7);
        send_short(16'd0);
    endtask

    task automatic test_random_traffic(input int target);
        int start;
        int frames;
        int sel;
        int len;
        start = taken_bytes;
        frames = 0;
        while (taken_bytes - start < target) begin
            if (frames % 16 == 15) begin
                drain();
                write_cfg(REG_HEAD_BYTE, pick_byte());
                write_cfg(REG_TAIL_BYTE, pick_byte());
                write_cfg(REG_TWO_BYTE_LENGTH, 8'($urandom_range(0, 1)));
            end
            sel = $urandom_range(0, 99);
            len = pick_len();
            if (sel < 70) begin
                build_frame(len, 1'b0, 1'b0);
                send_buf(len);
            end else if (sel < 78) begin
                build_frame(len, 1'b1, 1'b0);
                send_buf(len);
            end else if (sel < 84) begin
                build_frame(len, 1'b0, 1'b1);
                send_buf(len);
            end else if (sel < 90) begin
                send_short(cfg_model.two_byte_length ? 16'($urandom_range(0, 7))
                                                     : 16'($urandom_range(0, 6)));
            end else if (sel < 95) begin
                build_frame(len, 1'b0, 1'b0);
                send_buf($urandom_range(1, len - 1));
            end else begin
                send_random($urandom_range(1, 6));
            end
            close_frame();
            if ($urandom_range(0, 29) == 0)
                drain();
            frames++;
        end
    endtask

    task automatic test_mode_switch_mid_frame();
        drain();
        write_cfg(REG_TWO_BYTE_LENGTH, 8'd0);
        send_byte(cfg_model.head_byte);
        send_random(2);
        send_byte(8'h07);
        send_random(1);
        drain();
        // length 7 latched at byte 3 stays in force after the switch
        write_cfg(REG_TWO_BYTE_LENGTH, 8'd1);
        send_random(2);
        // a zero byte 3 is no length here; bytes 3-4 give nine
        send_byte(cfg_model.head_byte);
        send_random(2);
        send_byte(8'h00);
        send_byte(8'h09);
        close_frame();
    endtask

    task automatic test_long_frame();
        drain();
        write_cfg(REG_TWO_BYTE_LENGTH, 8'd1);
        build_frame(300, 1'b0, 1'b0);
        send_buf(300);
    endtask

    always @(posedge aclk) begin : receiver_ready
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin : check_echo
        result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_echo.size() == 0) begin
                $error("unexpected result: data_byte %0h byte_index %0d",
                       m_data_byte, m_byte_index);
                error_count++;
            end else begin
                exp_r = expected_echo.pop_front();
                if (m_data_byte !== exp_r.data_byte) begin
                    $error("data_byte expected %0h got %0h", exp_r.data_byte, m_data_byte);
                    error_count++;
                end
                if (m_byte_index !== exp_r.byte_index) begin
                    $error("byte_index expected %0d got %0d", exp_r.byte_index, m_byte_index);
                    error_count++;
                end
                if (m_frame_end !== exp_r.frame_end) begin
                    $error("frame_end expected %0b got %0b", exp_r.frame_end, m_frame_end);
                    error_count++;
                end
                if (m_frame_good !== exp_r.frame_good) begin
                    $error("frame_good expected %0b got %0b", exp_r.frame_good, m_frame_good);
                    error_count++;
                end
                if (m_frame_abort !== exp_r.frame_abort) begin
                    $error("frame_abort expected %0b got %0b",
                           exp_r.frame_abort, m_frame_abort);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        send_idle = 18;
        recv_idle = 50;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_one_byte_frames();
        test_two_byte_frames();
        test_random_traffic(380);
        drain();
        send_idle = 50;
        recv_idle = 18;
        test_random_traffic(380);
        drain();
        send_idle = 0;
        recv_idle = 0;
        test_random_traffic(380);
        test_mode_switch_mid_frame();
        test_long_frame();
        drain();
        repeat (8) @(posedge aclk);
        if (expected_echo.size() != 0) begin
            $error("%0d results never arrived", expected_echo.size());
            error_count++;
        end
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
